// ----- hw/rtl/hmp_pkg.sv -----
// Package for the hash message padder: request and result types, codes and
// constants. No dependencies; used by hash_message_padder.
`default_nettype none

package hmp_pkg;

  localparam int unsigned BlockBytes    = 64;
  localparam int unsigned WordsPerBlock = BlockBytes / 4;
  localparam int unsigned WordIdxW      = $clog2(WordsPerBlock);
  localparam int unsigned FillW         = $clog2(BlockBytes);

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic ACT_DATA   = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [31:0]         block_word;
    logic [WordIdxW-1:0] word_index;
    logic                last_of_block;
    logic                last_of_message;
  } out_rsp_t;

  function automatic logic [31:0] bswap32(input logic [31:0] w);
    bswap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hmp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hmp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/hash_message_padder.sv -----
// Top level of the hash message padder: gathers bytes into 64-byte blocks,
// pads on finish and streams each block as 16 words.
// Depends on hmp_pkg and hmp_ram.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------
//   in      | input     | in_valid_i / in_stall_o  | in_req_i  (in_req_t)
//   out     | output    | out_valid_o / out_stall_i| out_rsp_o (out_rsp_t)
//   cfg     | input     | cfg_we_i                 | cfg_wdata_i (1 bit)
//
// A data byte that does not complete a block is taken in without leaving idle.
// A block goes out one word at a time; each word passes through RAM read,
// output load and hand-off, and the hand-off waits out any output stall;
// a finish sends one or two blocks.
// The input is stalled for the whole emission. Reset leaves the block empty
// with the length written little-endian; no clearing pass is needed.
`default_nettype none

module hash_message_padder (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire hmp_pkg::in_req_t in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output hmp_pkg::out_rsp_t     out_rsp_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_wdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_HOLD
  } state_e;

  localparam int unsigned IdxW = hmp_pkg::WordIdxW;
  localparam int unsigned FilW = hmp_pkg::FillW;

  state_e            state_q;
  logic [FilW-1:0]   fill_q;
  logic [31:0]       asm_q;
  logic [63:0]       total_q;
  logic              len_be_q;
  logic [IdxW-1:0]   widx_q;
  logic [IdxW:0]     valid_words_q;
  logic              final_q;
  logic              second_q;
  logic              out_valid_q;
  hmp_pkg::out_rsp_t out_rsp_q;

  logic        in_accept;
  logic        is_finish;
  logic [31:0] data_word;
  logic [31:0] fin_word;
  logic        ram_we;
  logic [31:0] ram_wdata;
  logic [31:0] ram_rdata;
  logic [63:0] bit_len;
  logic [31:0] word_val;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_finish  = (in_req_i.action == hmp_pkg::ACT_FINISH);

  // Merge the new byte into its lane of the word being assembled.
  always_comb begin
    data_word = asm_q;
    data_word[{fill_q[1:0], 3'b000} +: 8] = in_req_i.data_byte;
  end

  // Partial word on finish: bytes held so far, then the marker, then zeros.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (2'(k) < fill_q[1:0]) begin
        fin_word[8*k +: 8] = asm_q[8*k +: 8];
      end else if (2'(k) == fill_q[1:0]) begin
        fin_word[8*k +: 8] = hmp_pkg::PAD_MARK;
      end else begin
        fin_word[8*k +: 8] = 8'h00;
      end
    end
  end

  assign ram_we    = in_accept && (is_finish || (fill_q[1:0] == 2'b11));
  assign ram_wdata = is_finish ? fin_word : data_word;

  hmp_ram #(
    .Width(32),
    .Depth(hmp_pkg::WordsPerBlock)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fill_q[FilW-1:2]),
    .wdata_i(ram_wdata),
    .raddr_i(widx_q),
    .rdata_o(ram_rdata)
  );

  assign bit_len = {total_q[60:0], 3'b000};

  // Words past the last one written this block are zero fill; the last two
  // words of the final block carry the bit length.
  always_comb begin
    if (final_q && (widx_q[IdxW-1:1] == {(IdxW-1){1'b1}})) begin
      if (len_be_q) begin
        word_val = widx_q[0] ? hmp_pkg::bswap32(bit_len[31:0])
                             : hmp_pkg::bswap32(bit_len[63:32]);
      end else begin
        word_val = widx_q[0] ? bit_len[63:32] : bit_len[31:0];
      end
    end else if ({1'b0, widx_q} < valid_words_q) begin
      word_val = ram_rdata;
    end else begin
      word_val = 32'h0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      fill_q        <= '0;
      asm_q         <= '0;
      total_q       <= '0;
      len_be_q      <= 1'b0;
      widx_q        <= '0;
      valid_words_q <= '0;
      final_q       <= 1'b0;
      second_q      <= 1'b0;
      out_valid_q   <= 1'b0;
      out_rsp_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        len_be_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            widx_q <= '0;
            if (is_finish) begin
              fill_q        <= '0;
              valid_words_q <= {1'b0, fill_q[FilW-1:2]} + 1'b1;
              // Marker lands at byte 56 or later: the length needs a second block.
              second_q      <= (fill_q[FilW-1:3] == {(FilW-3){1'b1}});
              final_q       <= (fill_q[FilW-1:3] != {(FilW-3){1'b1}});
              state_q       <= ST_READ;
            end else begin
              asm_q   <= data_word;
              fill_q  <= fill_q + 1'b1;
              total_q <= total_q + 64'd1;
              if (fill_q == {FilW{1'b1}}) begin
                valid_words_q <= (IdxW + 1)'(hmp_pkg::WordsPerBlock);
                second_q      <= 1'b0;
                final_q       <= 1'b0;
                state_q       <= ST_READ;
              end
            end
          end
        end
        ST_READ: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          out_rsp_q.block_word      <= word_val;
          out_rsp_q.word_index      <= widx_q;
          out_rsp_q.last_of_block   <= (widx_q == {IdxW{1'b1}});
          out_rsp_q.last_of_message <= final_q && (widx_q == {IdxW{1'b1}});
          out_valid_q               <= 1'b1;
          state_q                   <= ST_HOLD;
        end
        ST_HOLD: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (widx_q == {IdxW{1'b1}}) begin
              if (second_q) begin
                second_q      <= 1'b0;
                final_q       <= 1'b1;
                valid_words_q <= '0;
                widx_q        <= '0;
                state_q       <= ST_READ;
              end else begin
                if (final_q) begin
                  total_q <= '0;
                end
                state_q <= ST_IDLE;
              end
            end else begin
              widx_q  <= widx_q + 1'b1;
              state_q <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Results only appear while the input side is held off.
  a_out_only_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result presented while input is accepted");

  // After the final word of a message is taken, the block is empty again.
  a_clear_after_message : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_rsp_o.last_of_message
      |=> (fill_q == '0) && (total_q == '0) && !in_stall_o)
    else $error("padder not cleared after final word");

  // The count of written words never exceeds one block.
  a_valid_words_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_words_q <= (IdxW + 1)'(hmp_pkg::WordsPerBlock))
    else $error("written word count out of range");

  // A data byte that completes a block starts an emission on the next cycle.
  a_full_block_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !is_finish && (fill_q == {FilW{1'b1}})
      |=> (state_q == ST_READ) && (widx_q == '0) && !final_q)
    else $error("full block did not start emission");

endmodule

`default_nettype wire
